// ===== hw/rtl/gvsa_pkg.sv =====
// Shared types and constants for the generational voice slot allocator.
`timescale 1ns / 1ps

package gvsa_pkg;

    localparam int GEN_W   = 16;
    localparam int IDX_W   = 16;
    localparam int OWNER_W = 16;

    typedef enum logic [1:0] {
        MODE_ACQUIRE = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_QUERY   = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        STAT_REUSED  = 3'd0,
        STAT_NEW     = 3'd1,
        STAT_NOFREE  = 3'd2,
        STAT_OK      = 3'd3,
        STAT_INVALID = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_EVAL,
        FSM_ALLOC,
        FSM_DONE
    } fsm_t;

    // One voice slot as held in the slot memory.
    typedef struct packed {
        logic [GEN_W-1:0]   gen;
        logic [OWNER_W-1:0] owner;
        logic               playing;
        logic               looping;
    } slot_t;

endpackage

// ===== hw/rtl/gvsa_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
`timescale 1ns / 1ps

module gvsa_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 34,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/generational_voice_slot_allocator.sv =====
// Top level of the generational voice slot allocator.
`timescale 1ns / 1ps

// Hands out voice slots as 32-bit handles (generation in bits 31..16, slot
// index in 15..0). A handle is live when its index is below SLOTS, the slot
// is playing and the generations match. Slot state (generation, owner,
// playing, looping) sits in one synchronous RAM, free indices in a LIFO
// stack RAM with its fill count in a register. After reset the block runs a
// clearing pass (in_stall high) that zeroes every slot and loads the stack
// with 0..SLOTS-1. Requests are handled one at a time: each goes from
// accept through EVAL and DONE back to IDLE, and a fresh allocation also
// passes through ALLOC, because the popped index needs a second read of
// the slot RAM before its generation can be advanced. The result sits in
// an output register, so a new request is taken while a result still
// waits on out_stall; the block only holds off finishing the next one
// until that register is free.
module generational_voice_slot_allocator #(
    parameter int SLOTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [31:0] handle,
    input  logic [15:0] owner_id,
    input  logic        loop_flag,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [31:0] handle_out,
    output logic        playing,
    output logic        looping,
    output logic [15:0] slot_owner
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;   // slot index bits
    localparam int CW = $clog2(SLOTS + 1);                  // free count bits
    localparam int SW = $bits(gvsa_pkg::slot_t);

    // FSM and control
    gvsa_pkg::fsm_t state_reg, state_next;
    logic [IW-1:0]  clr_reg, clr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [CW-1:0]  cnt_dec;

    // captured request
    logic [1:0]     mode_reg;
    logic [31:0]    hnd_reg;
    logic [15:0]    own_reg;
    logic           loop_reg;
    logic [IW-1:0]  pop_reg, pop_next;

    // staged result
    logic [2:0]     res_status_reg, res_status_next;
    logic [31:0]    res_handle_reg, res_handle_next;
    logic           res_play_reg, res_play_next;
    logic           res_loop_reg, res_loop_next;
    logic [15:0]    res_owner_reg, res_owner_next;

    // output register
    logic           out_valid_reg, out_valid_next;
    logic [2:0]     out_status_reg;
    logic [31:0]    out_handle_reg;
    logic           out_play_reg;
    logic           out_loop_reg;
    logic [15:0]    out_owner_reg;
    logic           out_load;

    // RAM ports
    logic           slot_we, slot_re;
    logic [IW-1:0]  slot_wa, slot_ra;
    gvsa_pkg::slot_t slot_wd, slot_rd;
    logic           stk_we, stk_re;
    logic [IW-1:0]  stk_wa, stk_ra, stk_wd, stk_rd;

    logic           accept;
    logic           in_range;
    logic           hnd_live;
    logic [IW-1:0]  hnd_idx;

    gvsa_ram #(
        .DEPTH (SLOTS),
        .WIDTH (SW),
        .AW    (IW)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_wa),
        .wdata (slot_wd),
        .re    (slot_re),
        .raddr (slot_ra),
        .rdata (slot_rd)
    );

    gvsa_ram #(
        .DEPTH (SLOTS),
        .WIDTH (IW),
        .AW    (IW)
    ) u_free_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_wa),
        .wdata (stk_wd),
        .re    (stk_re),
        .raddr (stk_ra),
        .rdata (stk_rd)
    );

    assign in_stall = (state_reg != gvsa_pkg::FSM_IDLE);
    assign accept   = in_valid && !in_stall;
    assign cnt_dec  = cnt_reg - CW'(1);

    // liveness of the captured handle, checked against the slot just read
    assign hnd_idx  = hnd_reg[IW-1:0];
    assign in_range = ({1'b0, hnd_reg[15:0]} < 17'(SLOTS));
    assign hnd_live = in_range && slot_rd.playing && (slot_rd.gen == hnd_reg[31:16]);

    assign out_load = (state_reg == gvsa_pkg::FSM_DONE) && (!out_valid_reg || !out_stall);
    assign out_valid_next = out_load || (out_valid_reg && out_stall);

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        cnt_next        = cnt_reg;
        pop_next        = pop_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        res_play_next   = res_play_reg;
        res_loop_next   = res_loop_reg;
        res_owner_next  = res_owner_reg;

        slot_we = 1'b0;
        slot_wa = hnd_idx;
        slot_wd = slot_rd;
        slot_re = 1'b0;
        slot_ra = handle[IW-1:0];
        stk_we  = 1'b0;
        stk_wa  = cnt_reg[IW-1:0];
        stk_wd  = hnd_idx;
        stk_re  = 1'b0;
        stk_ra  = cnt_dec[IW-1:0];

        case (state_reg)
            gvsa_pkg::FSM_CLEAR:
            begin
                // zero one slot and seed one stack entry per cycle
                slot_we = 1'b1;
                slot_wa = clr_reg;
                slot_wd = '0;
                stk_we  = 1'b1;
                stk_wa  = clr_reg;
                stk_wd  = clr_reg;
                clr_next = clr_reg + IW'(1);
                if (clr_reg == IW'(SLOTS - 1))
                begin
                    state_next = gvsa_pkg::FSM_IDLE;
                end
            end

            gvsa_pkg::FSM_IDLE:
            begin
                // read the addressed slot and the stack top in parallel
                if (accept)
                begin
                    slot_re    = 1'b1;
                    stk_re     = 1'b1;
                    state_next = gvsa_pkg::FSM_EVAL;
                end
            end

            gvsa_pkg::FSM_EVAL:
            begin
                res_status_next = gvsa_pkg::STAT_INVALID;
                res_handle_next = '0;
                res_play_next   = 1'b0;
                res_loop_next   = 1'b0;
                res_owner_next  = '0;
                state_next      = gvsa_pkg::FSM_DONE;
                case (mode_reg)
                    gvsa_pkg::MODE_ACQUIRE:
                    begin
                        if (hnd_live)
                        begin
                            slot_we         = 1'b1;
                            slot_wd.playing = 1'b1;
                            slot_wd.looping = loop_reg;
                            res_status_next = gvsa_pkg::STAT_REUSED;
                            res_handle_next = {slot_rd.gen, 16'(hnd_idx)};
                            res_play_next   = 1'b1;
                            res_loop_next   = loop_reg;
                            res_owner_next  = slot_rd.owner;
                        end
                        else if (cnt_reg != '0)
                        begin
                            // pop, then fetch the popped slot's generation
                            cnt_next   = cnt_dec;
                            pop_next   = stk_rd;
                            slot_re    = 1'b1;
                            slot_ra    = stk_rd;
                            state_next = gvsa_pkg::FSM_ALLOC;
                        end
                        else
                        begin
                            res_status_next = gvsa_pkg::STAT_NOFREE;
                        end
                    end

                    gvsa_pkg::MODE_RELEASE:
                    begin
                        if (hnd_live)
                        begin
                            slot_we         = 1'b1;
                            slot_wd.playing = 1'b0;
                            if (cnt_reg < CW'(SLOTS))
                            begin
                                stk_we   = 1'b1;
                                cnt_next = cnt_reg + CW'(1);
                            end
                            res_status_next = gvsa_pkg::STAT_OK;
                            res_loop_next   = slot_rd.looping;
                            res_owner_next  = slot_rd.owner;
                        end
                    end

                    gvsa_pkg::MODE_QUERY:
                    begin
                        if (hnd_live)
                        begin
                            res_status_next = gvsa_pkg::STAT_OK;
                            res_play_next   = slot_rd.playing;
                            res_loop_next   = slot_rd.looping;
                            res_owner_next  = slot_rd.owner;
                        end
                    end

                    default:
                    begin
                        res_status_next = gvsa_pkg::STAT_INVALID;
                    end
                endcase
            end

            gvsa_pkg::FSM_ALLOC:
            begin
                slot_we         = 1'b1;
                slot_wa         = pop_reg;
                slot_wd.gen     = slot_rd.gen + 16'd1;
                slot_wd.owner   = own_reg;
                slot_wd.playing = 1'b1;
                slot_wd.looping = loop_reg;
                res_status_next = gvsa_pkg::STAT_NEW;
                res_handle_next = {slot_rd.gen + 16'd1, 16'(pop_reg)};
                res_play_next   = 1'b1;
                res_loop_next   = loop_reg;
                res_owner_next  = own_reg;
                state_next      = gvsa_pkg::FSM_DONE;
            end

            gvsa_pkg::FSM_DONE:
            begin
                if (out_load)
                begin
                    state_next = gvsa_pkg::FSM_IDLE;
                end
            end

            default:
            begin
                state_next = gvsa_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gvsa_pkg::FSM_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= CW'(SLOTS);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode;
            hnd_reg  <= handle;
            own_reg  <= owner_id;
            loop_reg <= loop_flag;
        end
        pop_reg        <= pop_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        res_play_reg   <= res_play_next;
        res_loop_reg   <= res_loop_next;
        res_owner_reg  <= res_owner_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_handle_reg <= res_handle_reg;
            out_play_reg   <= res_play_reg;
            out_loop_reg   <= res_loop_reg;
            out_owner_reg  <= res_owner_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign handle_out = out_handle_reg;
    assign playing    = out_play_reg;
    assign looping    = out_loop_reg;
    assign slot_owner = out_owner_reg;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the generational voice slot allocator.
`timescale 1ns / 1ps

// Every accepted request runs through a behavioral copy of the slot table.
// That copy covers the generation per slot, owner, playing and looping flags,
// and the LIFO stack of free indices. The reply it predicts is queued and
// compared field by field with the next reply the block hands out.
//
// Stimulus, in order:
//   - a table of hand-picked requests: handle 0 after reset, indices at and
//     above the slot count, wrong generations, the unused mode, repeated
//     release, reuse that must keep the owner, stale handles on acquire;
//   - acquires until the free stack runs dry, then refused acquires;
//   - random epochs, each with its own leaning toward allocation or release,
//     built mostly from live handles so the table keeps churning;
//   - one slot cycled through release/acquire a few times, then its live
//     and its stale handle queried.
// Both sides idle a random gap per request with calm stretches between. The
// result side also holds off once for a long stretch so the block backs up.
module testbench;

    localparam int SLOTS       = 64;
    localparam int STALL_LIMIT = 2000;   // cycles without any handshake

    typedef struct packed {
        gvsa_pkg::status_t status;
        logic [31:0]       handle_out;
        logic              playing;
        logic              looping;
        logic [15:0]       owner;
    } slot_reply_t;

    // One row of the directed table. When "typed" is set, "want" is the
    // reply written by hand; otherwise the reply comes from the slot mirror.
    typedef struct packed {
        gvsa_pkg::mode_t m;
        logic [31:0]     h;
        logic [15:0]     o;
        logic            l;
        logic            typed;
        slot_reply_t     want;
    } stim_row_t;

    localparam slot_reply_t NO_REPLY =
        '{gvsa_pkg::STAT_INVALID, 32'd0, 1'b0, 1'b0, 16'd0};
    localparam int          N_ROWS   = 21;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [1:0]  mode       = gvsa_pkg::MODE_NONE;
    logic [31:0] handle     = '0;
    logic [15:0] owner_id   = '0;
    logic        loop_flag  = 1'b0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [2:0]  status;
    logic [31:0] handle_out;
    logic        playing;
    logic        looping;
    logic [15:0] slot_owner;

    // Mirror of the slot table.
    int          spare_stack [SLOTS];
    int          free_fill;
    logic [15:0] mirror_gen [SLOTS];
    logic [15:0] mirror_owner [SLOTS];
    logic        mirror_live [SLOTS];
    logic        mirror_loop [SLOTS];

    slot_reply_t awaited_replies [$];
    stim_row_t   directed_rows [N_ROWS];
    int          mismatch_count = 0;
    int          quiet_cycles   = 0;
    bit          steady         = 1'b0;   // both sides stop idling
    bit          send_calm      = 1'b0;   // request side stops idling

    generational_voice_slot_allocator #(
        .SLOTS(SLOTS)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .handle     (handle),
        .owner_id   (owner_id),
        .loop_flag  (loop_flag),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .handle_out (handle_out),
        .playing    (playing),
        .looping    (looping),
        .slot_owner (slot_owner)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t ns: %s mismatch, got %h, want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Applies one request to the mirror and returns the reply it must give.
    // A handle counts as live only when its slot is playing and the
    // generations agree, so handle 0 and stale handles fall through.
    function automatic slot_reply_t predict_slot_reply(input gvsa_pkg::mode_t m,
                                                       input logic [31:0] h,
                                                       input logic [15:0] o,
                                                       input logic l);
        slot_reply_t r;
        int          idx;
        logic        live;
        r    = NO_REPLY;
        idx  = int'(h[15:0]);
        live = 1'b0;
        if (idx < SLOTS)
            live = mirror_live[idx] && (mirror_gen[idx] == h[31:16]);
        case (m)
            gvsa_pkg::MODE_ACQUIRE:
            begin
                if (live)
                    r.status = gvsa_pkg::STAT_REUSED;   // owner_id ignored on reuse
                else if (free_fill > 0)
                begin
                    free_fill--;
                    idx               = spare_stack[free_fill];
                    mirror_owner[idx] = o;
                    mirror_gen[idx]   = mirror_gen[idx] + 16'd1;   // wraps
                    r.status          = gvsa_pkg::STAT_NEW;
                end
                else
                begin
                    r.status = gvsa_pkg::STAT_NOFREE;
                    return r;
                end
                mirror_live[idx] = 1'b1;
                mirror_loop[idx] = l;
                r.handle_out     = {mirror_gen[idx], idx[15:0]};
                r.playing        = 1'b1;
                r.looping        = l;
                r.owner          = mirror_owner[idx];
            end
            gvsa_pkg::MODE_RELEASE:
            begin
                if (live)
                begin
                    mirror_live[idx] = 1'b0;
                    if (free_fill < SLOTS)
                    begin
                        spare_stack[free_fill] = idx;
                        free_fill++;
                    end
                    r.status  = gvsa_pkg::STAT_OK;
                    r.looping = mirror_loop[idx];
                    r.owner   = mirror_owner[idx];
                end
            end
            gvsa_pkg::MODE_QUERY:
            begin
                if (live)
                begin
                    r.status  = gvsa_pkg::STAT_OK;
                    r.playing = mirror_live[idx];
                    r.looping = mirror_loop[idx];
                    r.owner   = mirror_owner[idx];
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Offers one request, holds it until taken, then queues its reply and
    // draws the gap before the next one. A zero gap keeps in_valid high.
    task automatic send_request(input gvsa_pkg::mode_t m, input logic [31:0] h,
                                input logic [15:0] o, input logic l,
                                input logic typed = 1'b0,
                                input slot_reply_t want = NO_REPLY);
        slot_reply_t predicted;
        int          gap;
        mode      <= m;
        handle    <= h;
        owner_id  <= o;
        loop_flag <= l;
        in_valid  <= 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predicted = predict_slot_reply(m, h, o, l);
        if (typed)
            predicted = want;
        awaited_replies = {awaited_replies, predicted};
        gap = (steady || send_calm) ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Reply side: random hold-off per reply, calm stretches, and one long
    // hold-off while requests keep coming so the block fills and stalls.
    initial
    begin : reply_sink
        int  gap;
        int  taken;
        bit  calm;
        taken = 0;
        calm  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (taken % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            gap = (steady || calm) ? 0 : $urandom_range(0, 3);
            if (taken == 150)
                gap = 400;
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            taken++;
        end
    end

    // Every reply taken is matched against the oldest one awaited.
    always @(posedge clk)
    begin : reply_check
        slot_reply_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (awaited_replies.size() == 0)
                note_mismatch("reply with no request pending", 32'(status), 32'd0);
            else
            begin
                want = awaited_replies.pop_front();
                if (status !== want.status)
                    note_mismatch("status", 32'(status), 32'(want.status));
                if (handle_out !== want.handle_out)
                    note_mismatch("handle_out", handle_out, want.handle_out);
                if (playing !== want.playing)
                    note_mismatch("playing", 32'(playing), 32'(want.playing));
                if (looping !== want.looping)
                    note_mismatch("looping", 32'(looping), 32'(want.looping));
                if (slot_owner !== want.owner)
                    note_mismatch("slot_owner", 32'(slot_owner), 32'(want.owner));
            end
        end
    end

    // Ends the run when neither side has moved for too long.
    always @(posedge clk)
    begin
        if ((in_valid === 1'b1 && in_stall === 1'b0) ||
            (out_valid === 1'b1 && out_stall === 1'b0))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("generational_voice_slot_allocator regression: fail");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [31:0] live_h;
        logic [31:0] h;
        logic        have;
        int          pick;
        int          fill_pct;
        int          s;
        int          s2;
        int          k;
        for (k = 0; k < SLOTS; k++)
        begin
            spare_stack[k]  = k;
            mirror_gen[k]   = '0;
            mirror_owner[k] = '0;
            mirror_live[k]  = 1'b0;
            mirror_loop[k]  = 1'b0;
        end
        free_fill = SLOTS;

        // After reset the stack top is index 63, so the first allocation
        // hands out generation 1 of slot 63.
        directed_rows = '{
            '{gvsa_pkg::MODE_QUERY,   32'h0000_0000, 16'h0000, 1'b0, 1'b1, NO_REPLY},
            '{gvsa_pkg::MODE_RELEASE, 32'h0000_0000, 16'h0000, 1'b0, 1'b1, NO_REPLY},
            '{gvsa_pkg::MODE_ACQUIRE, 32'h0000_0000, 16'hFFFF, 1'b1, 1'b1,
              '{gvsa_pkg::STAT_NEW, 32'h0001_003F, 1'b1, 1'b1, 16'hFFFF}},
            '{gvsa_pkg::MODE_QUERY,   32'h0001_003F, 16'h0000, 1'b0, 1'b0, NO_REPLY},
            // reuse: owner stays, looping follows the new request
            '{gvsa_pkg::MODE_ACQUIRE, 32'h0001_003F, 16'h1234, 1'b0, 1'b0, NO_REPLY},
            '{gvsa_pkg::MODE_QUERY,   32'h0001_FFFF, 16'h0000, 1'b0, 1'b1, NO_REPLY},
            '{gvsa_pkg::MODE_QUERY,   32'h0001_0040, 16'h0000, 1'b0, 1'b1, NO_REPLY},
            '{gvsa_pkg::MODE_QUERY,   32'h0002_003F, 16'h0000, 1'b0, 1'b1, NO_REPLY},
            '{gvsa_pkg::MODE_NONE,    32'h0001_003F, 16'hFFFF, 1'b1, 1'b1, NO_REPLY},
            '{gvsa_pkg::MODE_RELEASE, 32'h0001_003F, 16'h0000, 1'b0, 1'b0, NO_REPLY},
            // second release of the same handle must be harmless
            '{gvsa_pkg::MODE_RELEASE, 32'h0001_003F, 16'h0000, 1'b0, 1'b1, NO_REPLY},
            '{gvsa_pkg::MODE_QUERY,   32'h0001_003F, 16'h0000, 1'b0, 1'b1, NO_REPLY},
            '{gvsa_pkg::MODE_ACQUIRE, 32'h0001_003F, 16'h0000, 1'b0, 1'b0, NO_REPLY},
            '{gvsa_pkg::MODE_ACQUIRE, 32'h0000_0000, 16'h8001, 1'b1, 1'b0, NO_REPLY},
            '{gvsa_pkg::MODE_QUERY,   32'hFFFF_FFFF, 16'h0000, 1'b0, 1'b1, NO_REPLY},
            '{gvsa_pkg::MODE_ACQUIRE, 32'hFFFF_FFFF, 16'h7FFE, 1'b0, 1'b0, NO_REPLY},
            '{gvsa_pkg::MODE_RELEASE, 32'h0002_003F, 16'h0000, 1'b0, 1'b0, NO_REPLY},
            '{gvsa_pkg::MODE_RELEASE, 32'h0001_003E, 16'h0000, 1'b0, 1'b0, NO_REPLY},
            '{gvsa_pkg::MODE_ACQUIRE, 32'h0000_0000, 16'h5555, 1'b1, 1'b0, NO_REPLY},
            '{gvsa_pkg::MODE_QUERY,   32'h0000_0000, 16'h0000, 1'b0, 1'b1, NO_REPLY},
            '{gvsa_pkg::MODE_NONE,    32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, NO_REPLY}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;   // the block clears its tables before taking requests

        for (k = 0; k < N_ROWS; k++)
            send_request(directed_rows[k].m, directed_rows[k].h, directed_rows[k].o,
                         directed_rows[k].l, directed_rows[k].typed,
                         directed_rows[k].want);

        // Drain the free stack, then try twice more on an empty stack.
        while (free_fill > 0)
            send_request(gvsa_pkg::MODE_ACQUIRE, 32'd0, 16'($urandom), 1'($urandom));
        repeat (2)
            send_request(gvsa_pkg::MODE_ACQUIRE, 32'd0, 16'($urandom), 1'($urandom));

        // Random epochs. Each leans toward filling or draining the table;
        // most requests carry live handles so slots keep changing hands.
        for (int e = 0; e < 12; e++)
        begin
            fill_pct  = $urandom_range(15, 90);
            send_calm = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 100; n++)
            begin
                have   = 1'b0;
                live_h = '0;
                s      = $urandom_range(0, SLOTS - 1);
                for (k = 0; k < SLOTS; k++)
                begin
                    s2 = (s + k) % SLOTS;
                    if (!have && mirror_live[s2])
                    begin
                        have   = 1'b1;
                        live_h = {mirror_gen[s2], s2[15:0]};
                    end
                end
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    // noise: any mode, any handle
                    send_request(gvsa_pkg::mode_t'($urandom_range(0, 3)), $urandom,
                                 16'($urandom), 1'($urandom));
                else if (pick < 16)
                begin
                    // near miss: generation off by one or index out of range
                    h = have ? live_h
                             : {16'($urandom), 16'($urandom_range(0, SLOTS - 1))};
                    case ($urandom_range(0, 2))
                        0:       h[31:16] = h[31:16] + 16'd1;
                        1:       h[31:16] = h[31:16] - 16'd1;
                        default: h[15:0]  = 16'($urandom_range(SLOTS, 65535));
                    endcase
                    send_request(gvsa_pkg::mode_t'($urandom_range(0, 2)), h,
                                 16'($urandom), 1'($urandom));
                end
                else if (pick < 26 && have)
                    send_request(gvsa_pkg::MODE_QUERY, live_h, 16'($urandom),
                                 1'($urandom));
                else if (pick < 34 && have)
                    send_request(gvsa_pkg::MODE_ACQUIRE, live_h, 16'($urandom),
                                 1'($urandom));
                else if (!have || $urandom_range(0, 99) < fill_pct)
                    send_request(gvsa_pkg::MODE_ACQUIRE,
                                 $urandom_range(0, 1) ? 32'd0 : $urandom,
                                 16'($urandom), 1'($urandom));
                else
                    send_request(gvsa_pkg::MODE_RELEASE, live_h, 16'($urandom),
                                 1'($urandom));
            end
        end
        send_calm = 1'b0;

        // Release and re-acquire one slot back to back. LIFO order hands
        // the same index straight back, one generation further each time.
        steady = 1'b1;
        if (free_fill == 0)
        begin
            have = 1'b0;
            for (k = 0; k < SLOTS; k++)
                if (!have && mirror_live[k])
                begin
                    have = 1'b1;
                    send_request(gvsa_pkg::MODE_RELEASE, {mirror_gen[k], k[15:0]},
                                 16'($urandom), 1'($urandom));
                end
        end
        s = spare_stack[free_fill - 1];
        send_request(gvsa_pkg::MODE_ACQUIRE, 32'd0, 16'($urandom), 1'($urandom));
        for (k = 0; k < 8; k++)
        begin
            send_request(gvsa_pkg::MODE_RELEASE, {mirror_gen[s], s[15:0]},
                         16'($urandom), 1'($urandom));
            send_request(gvsa_pkg::MODE_ACQUIRE, 32'd0, 16'($urandom), 1'($urandom));
        end
        // the live handle answers, the one a generation back is stale
        send_request(gvsa_pkg::MODE_QUERY, {mirror_gen[s], s[15:0]},
                     16'($urandom), 1'($urandom));
        send_request(gvsa_pkg::MODE_QUERY, {mirror_gen[s] - 16'd1, s[15:0]},
                     16'($urandom), 1'($urandom));
        send_request(gvsa_pkg::MODE_RELEASE, {mirror_gen[s], s[15:0]},
                     16'($urandom), 1'($urandom));
        in_valid <= 1'b0;

        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("generational_voice_slot_allocator regression: pass");
        else
            $display("generational_voice_slot_allocator regression: fail");
        $finish;
    end

endmodule

// ===== generational_voice_slot_allocator.f =====
hw/rtl/gvsa_pkg.sv
hw/rtl/gvsa_ram.sv
hw/rtl/generational_voice_slot_allocator.sv
dv/testbench.sv
